### rtl/pcx_pkg.sv
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared constants, codes and types of the packet chain XOR codec.
// ----------------------------------------------------------------------------
`default_nettype none

package pcx_pkg;

  // Payload store geometry.
  localparam int PAYLOAD_MAX  = 1024;
  localparam int HEADER_BYTES = 5;
  localparam int ADDR_W       = $clog2(PAYLOAD_MAX);
  localparam int CNT_W        = $clog2(PAYLOAD_MAX + 1);
  localparam int POS_W        = $clog2(PAYLOAD_MAX + HEADER_BYTES);

  // Decoder position and length widths follow the 16-bit length field.
  localparam int DLEN_W = 16;
  localparam int DPOS_W = 17;

  // Header byte positions of a framed packet.
  localparam int HDR_CODE     = 0;
  localparam int HDR_LEN_LO   = 1;
  localparam int HDR_LEN_HI   = 2;
  localparam int HDR_KEY      = 3;
  localparam int HDR_CHECKSUM = 4;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_PULL   = 2'd1,
    OP_DECODE = 2'd2
  } pcx_op_e;

  // Configuration register indexes.
  localparam logic CFG_FIXED_KEY   = 1'b0;
  localparam logic CFG_PACKET_CODE = 1'b1;

  // One result word as produced by the encoder or the decoder.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       ok;
  } pcx_result_t;

endpackage

`default_nettype wire

### rtl/pcx_payload_ram.sv
// ----------------------------------------------------------------------------
// pcx_payload_ram
// Payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_payload_ram
  import pcx_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem [PAYLOAD_MAX];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pcx_encoder.sv
// ----------------------------------------------------------------------------
// pcx_encoder
// Push side fills the payload store; pull side frames and scrambles a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_encoder
  import pcx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        pull_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [7:0]  rnd_i,
  input  wire logic [7:0]  fixed_key_i,
  input  wire logic [7:0]  packet_code_i,
  output pcx_result_t      res_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        key_q, key_d;
  logic [7:0]        prev_p_q, prev_p_d;
  logic [7:0]        prev_e_q, prev_e_d;

  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [15:0]       len16;
  logic [7:0]        plain, k, p, e;
  logic [POS_W:0]    total;
  logic              last;

  assign len16 = 16'(count_q);
  assign total = (POS_W + 1)'(HEADER_BYTES) + (POS_W + 1)'(count_q);
  assign last  = ({1'b0, pos_q} + 1'b1) >= total;

  // A push is taken only between packets and while the store has room.
  assign wr_en = push_i && (pos_q == '0) && (count_q < CNT_W'(PAYLOAD_MAX));

  // The read address tracks the next pull position, so the payload byte is
  // already registered when that pull arrives.
  assign rd_addr = ADDR_W'(pos_d - POS_W'(HEADER_BYTES));

  pcx_payload_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (data_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Two-stage scramble chain for the checksum and payload bytes.
  assign plain = (pos_q == POS_W'(HDR_CHECKSUM)) ? sum_q : rd_data;
  assign k     = 8'(pos_q - POS_W'(HDR_KEY));
  assign p     = plain ^ (prev_p_q + key_q + k);
  assign e     = p ^ (prev_e_q + fixed_key_i + k);

  // Next state and the result byte.
  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    pos_d      = pos_q;
    key_d      = key_q;
    prev_p_d   = prev_p_q;
    prev_e_d   = prev_e_q;
    res_o      = '0;

    if (wr_en) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + data_i;
    end

    if (pull_i) begin
      res_o.valid = 1'b1;
      res_o.last  = last;
      priority if (pos_q == POS_W'(HDR_CODE)) begin
        key_d      = rnd_i;
        prev_p_d   = '0;
        prev_e_d   = '0;
        res_o.data = packet_code_i;
      end else if (pos_q == POS_W'(HDR_LEN_LO)) begin
        res_o.data = len16[7:0];
      end else if (pos_q == POS_W'(HDR_LEN_HI)) begin
        res_o.data = len16[15:8];
      end else if (pos_q == POS_W'(HDR_KEY)) begin
        res_o.data = key_q;
      end else begin
        prev_p_d   = p;
        prev_e_d   = e;
        res_o.data = e;
      end
      if (last) begin
        pos_d   = '0;
        count_d = '0;
        sum_d   = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      pos_q    <= '0;
      key_q    <= '0;
      prev_p_q <= '0;
      prev_e_q <= '0;
    end else begin
      count_q  <= count_d;
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      key_q    <= key_d;
      prev_p_q <= prev_p_d;
      prev_e_q <= prev_e_d;
    end
  end

endmodule

`default_nettype wire

### rtl/pcx_decoder.sv
// ----------------------------------------------------------------------------
// pcx_decoder
// Parses a received packet, descrambles the payload and checks the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_decoder
  import pcx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       decode_i,
  input  wire logic [7:0] data_i,
  input  wire logic [7:0] fixed_key_i,
  output pcx_result_t     res_o
);

  logic [DPOS_W-1:0] pos_q, pos_d;
  logic [DLEN_W-1:0] len_q, len_d;
  logic [7:0]        key_q, key_d;
  logic [7:0]        chk_q, chk_d;
  logic [7:0]        prev_p_q, prev_p_d;
  logic [7:0]        prev_c_q, prev_c_d;
  logic [7:0]        sum_q, sum_d;

  logic [7:0] k, p, plain, chk_p, chk_plain, sum_new;
  logic       last;

  // Inverse chain for a payload byte.
  assign k       = 8'(pos_q - DPOS_W'(HDR_KEY));
  assign p       = data_i ^ (prev_c_q + fixed_key_i + k);
  assign plain   = p ^ (prev_p_q + key_q + k);
  assign sum_new = sum_q + plain;
  assign last    = (pos_q - DPOS_W'(HDR_CHECKSUM)) >= {1'b0, len_q};

  // Inverse chain for the checksum byte, where k is one.
  assign chk_p     = data_i ^ (fixed_key_i + 8'd1);
  assign chk_plain = chk_p ^ (key_q + 8'd1);

  // Next state and the result byte.
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    key_d    = key_q;
    chk_d    = chk_q;
    prev_p_d = prev_p_q;
    prev_c_d = prev_c_q;
    sum_d    = sum_q;
    res_o    = '0;

    if (decode_i) begin
      priority if (pos_q == DPOS_W'(HDR_CODE)) begin
        pos_d = pos_q + 1'b1;
      end else if (pos_q == DPOS_W'(HDR_LEN_LO)) begin
        len_d = {8'd0, data_i};
        pos_d = pos_q + 1'b1;
      end else if (pos_q == DPOS_W'(HDR_LEN_HI)) begin
        len_d = {data_i, len_q[7:0]};
        pos_d = pos_q + 1'b1;
      end else if (pos_q == DPOS_W'(HDR_KEY)) begin
        key_d = data_i;
        pos_d = pos_q + 1'b1;
      end else if (pos_q == DPOS_W'(HDR_CHECKSUM)) begin
        chk_d    = chk_plain;
        prev_p_d = chk_p;
        prev_c_d = data_i;
        sum_d    = '0;
        if (len_q == '0) begin
          // An empty payload finishes on the checksum byte.
          pos_d       = '0;
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          res_o.ok    = (chk_plain == 8'd0);
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end else begin
        prev_p_d    = p;
        prev_c_d    = data_i;
        sum_d       = sum_new;
        res_o.valid = 1'b1;
        res_o.data  = plain;
        if (last) begin
          pos_d      = '0;
          res_o.last = 1'b1;
          res_o.ok   = (sum_new == chk_q);
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      key_q    <= '0;
      chk_q    <= '0;
      prev_p_q <= '0;
      prev_c_q <= '0;
      sum_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      key_q    <= key_d;
      chk_q    <= chk_d;
      prev_p_q <= prev_p_d;
      prev_c_q <= prev_c_d;
      sum_q    <= sum_d;
    end
  end

endmodule

`default_nettype wire

### rtl/packet_chain_xor_codec_top.sv
// ----------------------------------------------------------------------------
// packet_chain_xor_codec_top
// Packet framing codec with a two-key chained XOR scramble.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle. Push words fill a 1024-byte
// payload store, pull words return the framed packet one byte at a time
// (code, length low and high, key, scrambled checksum, scrambled payload),
// and decode words return the descrambled payload of a received packet,
// with the checksum result on its last byte. The payload store read is
// issued from the next pull position, so pulls also run at one word per
// cycle; the only stall comes from the output register when the
// downstream side holds tready low. No clearing pass is needed after reset.
`default_nettype none

module packet_chain_xor_codec_top
  import pcx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,

  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] random_key
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation

  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // last_byte
  output logic             m_axis_tuser    // [0] checksum_ok
);

  logic [7:0]  fixed_key_q, packet_code_q;
  logic        accept;
  logic        push, pull, decode;
  pcx_result_t enc_res, dec_res, res;
  logic        out_valid_q, out_valid_d;
  pcx_result_t out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_key_q   <= '0;
      packet_code_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIXED_KEY:   fixed_key_q   <= cfg_data_i;
        CFG_PACKET_CODE: packet_code_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Operation decode of an accepted word.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push   = 1'b0;
    pull   = 1'b0;
    decode = 1'b0;
    if (accept) begin
      unique case (s_axis_tuser)
        OP_PUSH:   push   = 1'b1;
        OP_PULL:   pull   = 1'b1;
        OP_DECODE: decode = 1'b1;
        default:   ;
      endcase
    end
  end

  pcx_encoder u_encoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .pull_i        (pull),
    .data_i        (s_axis_tdata[7:0]),
    .rnd_i         (s_axis_tdata[15:8]),
    .fixed_key_i   (fixed_key_q),
    .packet_code_i (packet_code_q),
    .res_o         (enc_res)
  );

  pcx_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .decode_i    (decode),
    .data_i      (s_axis_tdata[7:0]),
    .fixed_key_i (fixed_key_q),
    .res_o       (dec_res)
  );

  // At most one of the two units produces a result in a cycle.
  assign res = enc_res.valid ? enc_res : dec_res;

  // Output register.
  always_comb begin
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.ok;

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packet chain XOR codec.
// ----------------------------------------------------------------------------
// Frames are built by pushing payload words and pulling the framed packet,
// and the pulled bytes are fed back through the decoder, sometimes with one
// byte damaged. A scoreboard holds its own copy of the codec state, predicts
// every result word and compares each result with the oldest prediction.
// Both stream sides stall in random bursts, and the scramble key and packet
// code are changed between phases while the block is idle.
`default_nettype none

module testbench;
  import pcx_pkg::*;

  // Operation code that the block has to ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1250;
  localparam int SETTLE_CYCLES = 16;
  localparam int CONFIG_EVERY  = 300;
  localparam int LONG_PAYLOAD  = 257;

  // Expected result word: byte, last flag and checksum flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ok;
  } codec_word_t;

  // Scoreboard: tracks the codec state and the pending result words.
  class codec_scoreboard;
    logic [7:0]        scramble_key   = '0;
    logic [7:0]        code_byte      = '0;
    logic [7:0]        payload_mem [PAYLOAD_MAX];
    logic [CNT_W-1:0]  fill_count     = '0;
    logic [7:0]        fill_sum       = '0;
    logic [POS_W-1:0]  frame_pos      = '0;
    logic [7:0]        tx_key         = '0;
    logic [7:0]        tx_plain_prev  = '0;
    logic [7:0]        tx_cipher_prev = '0;
    logic [DPOS_W-1:0] rx_pos         = '0;
    logic [DLEN_W-1:0] rx_len         = '0;
    logic [7:0]        rx_key         = '0;
    logic [7:0]        rx_check       = '0;
    logic [7:0]        rx_plain_prev  = '0;
    logic [7:0]        rx_cipher_prev = '0;
    logic [7:0]        rx_sum         = '0;
    codec_word_t       expected_words [$];
    logic [7:0]        framed_bytes [$];
    int                mismatches;
    int                frames_out;
    int                frames_in;
    int                frames_bad;

    function void write_register(logic index, logic [7:0] value);
      if (index == CFG_FIXED_KEY) begin
        scramble_key = value;
      end else begin
        code_byte = value;
      end
    endfunction

    // Notes one accepted input word and predicts its result, if any.
    function void note_word(logic [1:0] op, logic [7:0] data, logic [7:0] key);
      case (op)
        OP_PUSH: begin
          // Pushes are dropped while a frame is being pulled or the store is full.
          if (frame_pos == '0 && int'(fill_count) < PAYLOAD_MAX) begin
            payload_mem[fill_count[ADDR_W-1:0]] = data;
            fill_count = fill_count + 1'b1;
            fill_sum   = fill_sum + data;
          end
        end
        OP_PULL:   pull_byte(key);
        OP_DECODE: decode_byte(data);
        default: ;
      endcase
    endfunction

    // One byte of the framed packet: header, then the scrambled checksum and payload.
    function void pull_byte(logic [7:0] key);
      logic [7:0] plain;
      logic [7:0] k;
      logic [7:0] p;
      logic [7:0] b;
      logic       last;
      case (int'(frame_pos))
        HDR_CODE: begin
          tx_key         = key;
          tx_plain_prev  = '0;
          tx_cipher_prev = '0;
          b              = code_byte;
          framed_bytes.delete();
        end
        HDR_LEN_LO: b = fill_count[7:0];
        HDR_LEN_HI: b = 8'(fill_count >> 8);
        HDR_KEY:    b = tx_key;
        default: begin
          if (int'(frame_pos) == HDR_CHECKSUM) begin
            plain = fill_sum;
          end else begin
            plain = payload_mem[ADDR_W'(int'(frame_pos) - HEADER_BYTES)];
          end
          k = 8'(int'(frame_pos) - HDR_KEY);
          p = plain ^ (tx_plain_prev + tx_key + k);
          b = p ^ (tx_cipher_prev + scramble_key + k);
          tx_plain_prev  = p;
          tx_cipher_prev = b;
        end
      endcase
      last = (int'(frame_pos) + 1 >= HEADER_BYTES + int'(fill_count));
      framed_bytes.push_back(b);
      expected_words.push_back({b, last, 1'b0});
      if (last) begin
        frame_pos  = '0;
        fill_count = '0;
        fill_sum   = '0;
        frames_out++;
      end else begin
        frame_pos = frame_pos + 1'b1;
      end
    endfunction

    // One received byte: header bytes are absorbed, payload bytes are unscrambled.
    function void decode_byte(logic [7:0] c);
      logic [7:0] k;
      logic [7:0] p;
      logic [7:0] plain;
      case (int'(rx_pos))
        HDR_CODE: rx_pos = DPOS_W'(HDR_LEN_LO);
        HDR_LEN_LO: begin
          rx_len = {8'h00, c};
          rx_pos = DPOS_W'(HDR_LEN_HI);
        end
        HDR_LEN_HI: begin
          rx_len[15:8] = c;
          rx_pos       = DPOS_W'(HDR_KEY);
        end
        HDR_KEY: begin
          rx_key = c;
          rx_pos = DPOS_W'(HDR_CHECKSUM);
        end
        HDR_CHECKSUM: begin
          k              = 8'(HDR_CHECKSUM - HDR_KEY);
          p              = c ^ (scramble_key + k);
          rx_check       = p ^ (rx_key + k);
          rx_plain_prev  = p;
          rx_cipher_prev = c;
          rx_sum         = '0;
          // An empty payload closes the frame on the checksum byte itself.
          if (rx_len == '0) begin
            rx_pos = '0;
            finish_frame(8'h00, rx_check == 8'h00);
          end else begin
            rx_pos = DPOS_W'(HEADER_BYTES);
          end
        end
        default: begin
          k              = 8'(int'(rx_pos) - HDR_KEY);
          p              = c ^ (rx_cipher_prev + scramble_key + k);
          plain          = p ^ (rx_plain_prev + rx_key + k);
          rx_plain_prev  = p;
          rx_cipher_prev = c;
          rx_sum         = rx_sum + plain;
          if (int'(rx_pos) - HDR_CHECKSUM >= int'(rx_len)) begin
            rx_pos = '0;
            finish_frame(plain, rx_sum == rx_check);
          end else begin
            rx_pos = rx_pos + 1'b1;
            expected_words.push_back({plain, 1'b0, 1'b0});
          end
        end
      endcase
    endfunction

    function void finish_frame(logic [7:0] b, logic ok);
      expected_words.push_back({b, 1'b1, ok});
      frames_in++;
      if (!ok) frames_bad++;
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void check_word(logic [7:0] b, logic last, logic ok);
      codec_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: byte %h last %b ok %b", $time, b, last, ok);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (b !== want.data) begin
        $display("%0t: out_byte mismatch: expected %h actual %h", $time, want.data, b);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last_byte mismatch: expected %b actual %b", $time, want.last, last);
        mismatches++;
      end
      if (ok !== want.ok) begin
        $display("%0t: checksum_ok mismatch: expected %b actual %b", $time, want.ok, ok);
        mismatches++;
      end
    endfunction
  endclass

  // Clock, reset and block inputs, all known from time zero.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic [15:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tready  = 1'b0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  codec_scoreboard sb;
  bit              idle_on   = 1'b1;
  int              item_count;
  int              cfg_count;
  int              stall_left;

  always #4 clk = ~clk;

  packet_chain_xor_codec_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),    // [7:0] data_byte, [15:8] random_key
    .s_axis_tuser  (s_tuser),    // [1:0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),  // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast),  // last_byte
    .m_axis_tuser  (m_axis_tuser)   // [0] checksum_ok
  );

  // Input words are noted before results are checked, all at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_axis_tready) begin
        sb.note_word(s_tuser, s_tdata[7:0], s_tdata[15:8]);
      end
      if (m_axis_tvalid && m_tready) begin
        sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
    end
  end

  // Downstream backpressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offers one word and returns on the falling edge after it is taken.
  task automatic send_word(input logic [1:0] op, input logic [7:0] data,
                           input logic [7:0] key);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {key, data};
    s_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (op != OP_UNUSED) item_count++;
    @(negedge clk);
  endtask

  // Stops sending, waits for every pending result, then lets the block settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic configure(input logic [7:0] key, input logic [7:0] code);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIXED_KEY;
    cfg_data  <= key;
    @(negedge clk);
    cfg_index <= CFG_PACKET_CODE;
    cfg_data  <= code;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_register(CFG_FIXED_KEY, key);
    sb.write_register(CFG_PACKET_CODE, code);
    cfg_count++;
  endtask

  task automatic push_payload(input int count, input bit noisy);
    for (int i = 0; i < count; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_word(OP_UNUSED, 8'($urandom), 8'($urandom));
      end
      send_word(OP_PUSH, 8'($urandom), 8'($urandom));
    end
  endtask

  // Pulls a whole frame; noise between pulls is ignored by the block.
  task automatic pull_frame(input int payload, input logic [7:0] key, input bit noisy);
    int total;
    total = payload + HEADER_BYTES;
    for (int i = 0; i < total; i++) begin
      send_word(OP_PULL, 8'($urandom), key);
      if (noisy && i + 1 < total && $urandom_range(0, 15) == 0) begin
        send_word($urandom_range(0, 1) ? OP_PUSH : OP_UNUSED, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Feeds the last pulled frame to the decoder, optionally with one damaged byte.
  task automatic decode_frame(input bit corrupt);
    logic [7:0] frame [$];
    int unsigned at;
    frame = sb.framed_bytes;
    if (corrupt) begin
      at = $urandom_range(HDR_KEY, frame.size() - 1);
      frame[at] = frame[at] ^ 8'($urandom_range(1, 255));
    end
    foreach (frame[i]) send_word(OP_DECODE, frame[i], 8'($urandom));
  endtask

  // A received frame of random content with a short random length.
  task automatic decode_noise();
    int len;
    len = $urandom_range(0, 20);
    send_word(OP_DECODE, 8'($urandom), 8'($urandom));
    send_word(OP_DECODE, 8'(len), 8'($urandom));
    send_word(OP_DECODE, 8'h00, 8'($urandom));
    repeat (len + 2) send_word(OP_DECODE, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int size;
    int next_cfg;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty frame both ways, extreme payload bytes, ignored words.
    configure(8'hFF, 8'h00);
    pull_frame(0, 8'hFF, 1'b0);
    decode_frame(1'b0);
    send_word(OP_PUSH, 8'h00, 8'h00);
    send_word(OP_PUSH, 8'hFF, 8'hFF);
    send_word(OP_UNUSED, 8'hFF, 8'hFF);
    send_word(OP_PULL, 8'h00, 8'h00);
    send_word(OP_PUSH, 8'hA5, 8'h5A);
    repeat (6) send_word(OP_PULL, 8'hFF, 8'hFF);
    decode_frame(1'b0);

    // Long frame: the length high byte is nonzero.
    drain_results();
    configure(8'h00, 8'hFF);
    push_payload(LONG_PAYLOAD, 1'b0);
    pull_frame(LONG_PAYLOAD, 8'($urandom), 1'b0);
    decode_frame(1'b0);

    // Random frames with noise, damage and occasional register changes.
    next_cfg = item_count;
    while (item_count < RANDOM_ITEMS) begin
      if (item_count >= next_cfg) begin
        drain_results();
        case ($urandom_range(0, 3))
          0:       configure(8'h00, 8'h00);
          1:       configure(8'hFF, 8'hFF);
          default: configure(8'($urandom), 8'($urandom));
        endcase
        next_cfg += CONFIG_EVERY;
      end
      // The tail of the run goes without any idling.
      idle_on = (item_count < RANDOM_ITEMS - 200) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        size = $urandom_range(0, 24);
        push_payload(size, 1'b1);
        pull_frame(size, 8'($urandom), 1'b1);
        decode_frame($urandom_range(0, 3) == 0);
      end else begin
        decode_noise();
      end
    end

    drain_results();
    $display("Run covered %0d encoded and %0d decoded frames, %0d of them with a bad checksum,",
             sb.frames_out, sb.frames_in, sb.frames_bad);
    $display("under %0d register settings, including a frame longer than 255 bytes.",
             cfg_count);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("packet_chain_xor_codec_top regression: pass");
    end else begin
      $display("packet_chain_xor_codec_top regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("packet_chain_xor_codec_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/pcx_pkg.sv
rtl/pcx_payload_ram.sv
rtl/pcx_encoder.sv
rtl/pcx_decoder.sv
rtl/packet_chain_xor_codec_top.sv
bench/testbench.sv
